>>> design/statevector_gate_engine_macros.svh
// Assertion macros used by the state-vector gate engine.
`ifndef STATEVECTOR_GATE_ENGINE_MACROS_SVH
`define STATEVECTOR_GATE_ENGINE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SGE_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SGE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/sge_pkg.sv
package sge_pkg;

   localparam int MAX_QUBITS    = 10;
   localparam int AMP_FRAC_BITS = 16;

   localparam int AMP_W   = AMP_FRAC_BITS + 2;
   localparam int COEF_W  = 18;
   localparam int OPND_W  = (AMP_W > COEF_W) ? AMP_W : COEF_W;
   localparam int PROD_W  = 2 * OPND_W;
   localparam int ACC_W   = PROD_W + MAX_QUBITS + 2;
   localparam int ADDR_W  = MAX_QUBITS;
   localparam int DEPTH   = 1 << MAX_QUBITS;
   localparam int PAIR_W  = (MAX_QUBITS > 1) ? MAX_QUBITS - 1 : 1;
   localparam int WIRE_W  = 4;
   localparam int QREG_W  = 4;
   localparam int OP_W    = 3;
   localparam int QCNT_W  = $clog2(MAX_QUBITS + 1) + 1;
   localparam int ENTRY_W = 2 * AMP_W;

   localparam logic signed [AMP_W-1:0] AMP_ONE = AMP_W'(1) <<< AMP_FRAC_BITS;
   localparam logic [QREG_W-1:0] QUBITS_RESET = QREG_W'(MAX_QUBITS);

   typedef enum logic [OP_W-1:0] {
      OP_RESET  = 3'd0,
      OP_RX     = 3'd1,
      OP_RY     = 3'd2,
      OP_RZ     = 3'd3,
      OP_CNOT   = 3'd4,
      OP_MEAS_Z = 3'd5,
      OP_MEAS_X = 3'd6,
      OP_MEAS_Y = 3'd7
   } op_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_START,
      ST_RD_A,
      ST_RD_B,
      ST_PROD,
      ST_WR_A,
      ST_WR_B,
      ST_ACC,
      ST_RESULT
   } state_type;

   // Round a value with 2*F fraction bits to F bits, half up, then clamp to +/-1.0.
   function automatic logic signed [AMP_W-1:0] round_sat(input logic signed [ACC_W-1:0] x);
      logic signed [ACC_W-1:0] biased;
      logic signed [ACC_W-1:0] shifted;
      logic signed [AMP_W-1:0] res;
      biased  = x + (ACC_W'(1) <<< (AMP_FRAC_BITS - 1));
      shifted = biased >>> AMP_FRAC_BITS;
      if (shifted > ACC_W'(AMP_ONE)) begin
         res = AMP_ONE;
      end else if (shifted < -ACC_W'(AMP_ONE)) begin
         res = -AMP_ONE;
      end else begin
         res = shifted[AMP_W-1:0];
      end
      return res;
   endfunction

endpackage

>>> design/sge_req_if.sv
interface sge_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [sge_pkg::OP_W-1:0]             opcode;
   logic [sge_pkg::WIRE_W-1:0]           wire_req;
   logic [sge_pkg::WIRE_W-1:0]           second_wire;
   logic signed [sge_pkg::COEF_W-1:0]    cosine;
   logic signed [sge_pkg::COEF_W-1:0]    sine;

   modport source (output valid, opcode, wire_req, second_wire, cosine, sine, input ready);
   modport sink   (input valid, opcode, wire_req, second_wire, cosine, sine, output ready);
endinterface

>>> design/sge_rsp_if.sv
interface sge_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [sge_pkg::AMP_W-1:0]    expectation;
   logic [sge_pkg::WIRE_W-1:0]          measured_wire;

   modport source (output valid, expectation, measured_wire, input ready);
   modport sink   (input valid, expectation, measured_wire, output ready);
endinterface

>>> design/sge_csr_if.sv
interface sge_csr_if;
   logic                          valid;
   logic                          ready;
   logic [sge_pkg::QREG_W-1:0]    qubits_in_use;

   modport source (output valid, qubits_in_use, input ready);
   modport sink   (input valid, qubits_in_use, output ready);
endinterface

>>> design/statevector_gate_engine.sv
// State-vector gate engine. The block holds 2^n complex amplitudes (Q1.16 real and
// imaginary parts) in one single-ported synchronous RAM and applies one operation per
// request beat: reset to the ground state, RX/RY/RZ rotations with a given cosine and
// sine, CNOT, or a Z/X/Y expectation measurement on one wire.
// The csr channel writes the active qubit count; it is always ready and must only be
// written while the engine is idle. The req channel is ready only while the engine is
// idle. Each measurement produces one rsp beat; every other operation produces none.
// Through the single RAM port, amplitudes are walked in pairs (i, i|bit): a gate takes
// each pair through two reads, a multiply stage and two writes, and a measurement
// through two reads, a multiply stage and an accumulate step.
// A state reset (opcode 0) sweeps the whole RAM, one entry per cycle.
// After the reset input, the same clearing pass runs before the first request beat is
// taken; csr writes are taken during it.
// A finished measurement waits in the rsp output register while the receiver stalls.
// The engine keeps taking requests meanwhile; only a following measurement holds in its
// final state until the waiting result has been handed off.
module statevector_gate_engine (
   input  logic       clock,
   input  logic       reset,
   sge_req_if.sink    req,
   sge_rsp_if.source  rsp,
   sge_csr_if.sink    csr
);
   import sge_pkg::*;
   `include "statevector_gate_engine_macros.svh"

   state_type state_ff, state_in;

   logic [QREG_W-1:0]        qubits_ff, qubits_in;
   op_type                   op_ff, op_in;
   logic [WIRE_W-1:0]        pair_wire_ff, pair_wire_in;   // wire that splits the pairs
   logic [WIRE_W-1:0]        ctrl_ff, ctrl_in;             // CNOT control wire
   logic [WIRE_W-1:0]        meas_wire_ff, meas_wire_in;
   logic signed [COEF_W-1:0] cos_ff, cos_in;
   logic signed [COEF_W-1:0] sin_ff, sin_in;
   logic [PAIR_W-1:0]        pair_ff, pair_in;
   logic [ADDR_W-1:0]        clr_ff, clr_in;
   logic [ENTRY_W-1:0]       a_ff, a_in;
   logic [ENTRY_W-1:0]       b_ff, b_in;
   logic signed [PROD_W-1:0] prod_ff [8];
   logic signed [PROD_W-1:0] prod_in [8];
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [AMP_W-1:0]  rsp_exp_ff, rsp_exp_in;
   logic [WIRE_W-1:0]        rsp_wire_ff, rsp_wire_in;

   logic                     ram_en;
   logic                     ram_we;
   logic [ADDR_W-1:0]        ram_addr;
   logic [ENTRY_W-1:0]       ram_wdata;
   logic [ENTRY_W-1:0]       ram_rdata;

   logic [QCNT_W-1:0]        n_eff;
   logic [ADDR_W-1:0]        low_mask;
   logic [ADDR_W-1:0]        pair_ext;
   logic [ADDR_W-1:0]        i_addr;
   logic [ADDR_W-1:0]        j_addr;
   logic [PAIR_W-1:0]        last_pair;
   logic                     ctrl_set;
   logic                     req_fire;

   logic signed [AMP_W-1:0]  ar, ai, br, bi;
   logic signed [OPND_W-1:0] mx [8];
   logic signed [OPND_W-1:0] my [8];
   logic signed [ACC_W-1:0]  pe [8];
   logic signed [AMP_W-1:0]  new_ar, new_ai, new_br, new_bi;
   logic signed [ACC_W-1:0]  meas_term;
   logic signed [ACC_W-1:0]  acc_final;

   sge_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_amp_ram (
      .clock (clock),
      .en    (ram_en),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   // Out-of-range qubit counts are clamped into [1, MAX_QUBITS].
   always_comb begin
      priority if (qubits_ff == '0) begin
         n_eff = QCNT_W'(1);
      end else if (QCNT_W'(qubits_ff) > QCNT_W'(MAX_QUBITS)) begin
         n_eff = QCNT_W'(MAX_QUBITS);
      end else begin
         n_eff = QCNT_W'(qubits_ff);
      end
   end

   // Pair number k becomes i by inserting a zero at the pair wire's bit position.
   assign low_mask  = (ADDR_W'(1) << pair_wire_ff) - ADDR_W'(1);
   assign pair_ext  = ADDR_W'(pair_ff);
   assign i_addr    = ((pair_ext & ~low_mask) << 1) | (pair_ext & low_mask);
   assign j_addr    = i_addr | (ADDR_W'(1) << pair_wire_ff);
   assign last_pair = (PAIR_W'(1) << (n_eff - QCNT_W'(1))) - PAIR_W'(1);
   assign ctrl_set  = (i_addr & (ADDR_W'(1) << ctrl_ff)) != '0;
   assign req_fire  = req.valid && req.ready;

   // Multiplier operands: slots 0-3 pair the four parts with the cosine or, for a
   // measurement, with themselves (Z) or their partners (X, Y); slots 4-7 always take the sine.
   assign ar = a_ff[ENTRY_W-1:AMP_W];
   assign ai = a_ff[AMP_W-1:0];
   assign br = ram_rdata[ENTRY_W-1:AMP_W];
   assign bi = ram_rdata[AMP_W-1:0];

   always_comb begin
      mx[0] = OPND_W'(ar);
      mx[1] = OPND_W'(ai);
      mx[2] = OPND_W'(br);
      mx[3] = OPND_W'(bi);
      mx[4] = OPND_W'(ar);
      mx[5] = OPND_W'(ai);
      mx[6] = OPND_W'(br);
      mx[7] = OPND_W'(bi);
      for (int k = 4; k < 8; k++) begin
         my[k] = OPND_W'(sin_ff);
      end
      unique case (op_ff)
         OP_MEAS_Z: begin
            my[0] = OPND_W'(ar);
            my[1] = OPND_W'(ai);
            my[2] = OPND_W'(br);
            my[3] = OPND_W'(bi);
         end
         OP_MEAS_X: begin
            my[0] = OPND_W'(br);
            my[1] = OPND_W'(bi);
            my[2] = '0;
            my[3] = '0;
         end
         OP_MEAS_Y: begin
            my[0] = OPND_W'(bi);
            my[1] = OPND_W'(br);
            my[2] = '0;
            my[3] = '0;
         end
         default: begin
            for (int k = 0; k < 4; k++) begin
               my[k] = OPND_W'(cos_ff);
            end
         end
      endcase
      for (int k = 0; k < 8; k++) begin
         prod_in[k] = mx[k] * my[k];
         pe[k]      = ACC_W'(prod_ff[k]);
      end
   end

   // Products: 0 ar*c, 1 ai*c, 2 br*c, 3 bi*c, 4 ar*s, 5 ai*s, 6 br*s, 7 bi*s.
   always_comb begin
      unique case (op_ff)
         OP_RX: begin
            new_ar = round_sat(pe[0] + pe[7]);
            new_ai = round_sat(pe[1] - pe[6]);
            new_br = round_sat(pe[2] + pe[5]);
            new_bi = round_sat(pe[3] - pe[4]);
         end
         OP_RY: begin
            new_ar = round_sat(pe[0] - pe[6]);
            new_ai = round_sat(pe[1] - pe[7]);
            new_br = round_sat(pe[4] + pe[2]);
            new_bi = round_sat(pe[5] + pe[3]);
         end
         default: begin
            // RZ: the phase sign flips between the zero half and the one half.
            new_ar = round_sat(pe[0] + pe[5]);
            new_ai = round_sat(pe[1] - pe[4]);
            new_br = round_sat(pe[2] - pe[7]);
            new_bi = round_sat(pe[6] + pe[3]);
         end
      endcase
      unique case (op_ff)
         OP_MEAS_Z: meas_term = pe[0] + pe[1] - pe[2] - pe[3];
         OP_MEAS_X: meas_term = pe[0] + pe[1];
         default:   meas_term = pe[0] - pe[1];
      endcase
      acc_final = (op_ff == OP_MEAS_Z) ? acc_ff : (acc_ff <<< 1);
   end

   always_comb begin
      state_in     = state_ff;
      qubits_in    = qubits_ff;
      op_in        = op_ff;
      pair_wire_in = pair_wire_ff;
      ctrl_in      = ctrl_ff;
      meas_wire_in = meas_wire_ff;
      cos_in       = cos_ff;
      sin_in       = sin_ff;
      pair_in      = pair_ff;
      clr_in       = clr_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_exp_in   = rsp_exp_ff;
      rsp_wire_in  = rsp_wire_ff;
      ram_en       = 1'b0;
      ram_we       = 1'b0;
      ram_addr     = i_addr;
      ram_wdata    = {new_ar, new_ai};
      req.ready    = 1'b0;

      if (csr.valid) begin
         qubits_in = csr.qubits_in_use;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            ram_en    = 1'b1;
            ram_we    = 1'b1;
            ram_addr  = clr_ff;
            ram_wdata = (clr_ff == '0) ? {AMP_ONE, AMP_W'(0)} : '0;
            clr_in    = clr_ff + ADDR_W'(1);
            if (clr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req.ready = 1'b1;
            if (req_fire) begin
               op_in        = op_type'(req.opcode);
               pair_wire_in = (op_type'(req.opcode) == OP_CNOT) ? req.second_wire
                                                                : req.wire_req;
               ctrl_in      = req.wire_req;
               meas_wire_in = req.wire_req;
               cos_in       = req.cosine;
               sin_in       = req.sine;
               pair_in      = '0;
               clr_in       = '0;
               acc_in       = '0;
               state_in     = ST_START;
            end
         end
         ST_START: begin
            unique case (op_ff)
               OP_RESET: state_in = ST_CLEAR;
               OP_CNOT: begin
                  if (QCNT_W'(ctrl_ff) < n_eff && QCNT_W'(pair_wire_ff) < n_eff
                      && ctrl_ff != pair_wire_ff) begin
                     state_in = ST_RD_A;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
               OP_MEAS_Z, OP_MEAS_X, OP_MEAS_Y: begin
                  state_in = (QCNT_W'(pair_wire_ff) < n_eff) ? ST_RD_A : ST_RESULT;
               end
               default: begin
                  state_in = (QCNT_W'(pair_wire_ff) < n_eff) ? ST_RD_A : ST_IDLE;
               end
            endcase
         end
         ST_RD_A: begin
            ram_en   = 1'b1;
            ram_addr = i_addr;
            state_in = ST_RD_B;
         end
         ST_RD_B: begin
            ram_en   = 1'b1;
            ram_addr = j_addr;
            a_in     = ram_rdata;
            state_in = ST_PROD;
         end
         ST_PROD: begin
            b_in = ram_rdata;
            unique case (op_ff)
               OP_MEAS_Z, OP_MEAS_X, OP_MEAS_Y: state_in = ST_ACC;
               default:                         state_in = ST_WR_A;
            endcase
         end
         ST_WR_A: begin
            ram_en   = 1'b1;
            ram_we   = 1'b1;
            ram_addr = i_addr;
            if (op_ff == OP_CNOT) begin
               ram_wdata = ctrl_set ? b_ff : a_ff;
            end else begin
               ram_wdata = {new_ar, new_ai};
            end
            state_in = ST_WR_B;
         end
         ST_WR_B: begin
            ram_en   = 1'b1;
            ram_we   = 1'b1;
            ram_addr = j_addr;
            if (op_ff == OP_CNOT) begin
               ram_wdata = ctrl_set ? a_ff : b_ff;
            end else begin
               ram_wdata = {new_br, new_bi};
            end
            if (pair_ff == last_pair) begin
               state_in = ST_IDLE;
            end else begin
               pair_in  = pair_ff + PAIR_W'(1);
               state_in = ST_RD_A;
            end
         end
         ST_ACC: begin
            acc_in = acc_ff + meas_term;
            if (pair_ff == last_pair) begin
               state_in = ST_RESULT;
            end else begin
               pair_in  = pair_ff + PAIR_W'(1);
               state_in = ST_RD_A;
            end
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_exp_in   = round_sat(acc_final);
               rsp_wire_in  = meas_wire_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         qubits_ff    <= QUBITS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         qubits_ff    <= qubits_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      pair_wire_ff <= pair_wire_in;
      ctrl_ff      <= ctrl_in;
      meas_wire_ff <= meas_wire_in;
      cos_ff       <= cos_in;
      sin_ff       <= sin_in;
      pair_ff      <= pair_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      acc_ff       <= acc_in;
      rsp_exp_ff   <= rsp_exp_in;
      rsp_wire_ff  <= rsp_wire_in;
      for (int k = 0; k < 8; k++) begin
         prod_ff[k] <= prod_in[k];
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.expectation   = rsp_exp_ff;
   assign rsp.measured_wire = rsp_wire_ff;
   assign csr.ready         = 1'b1;

   `SGE_ASSERT_SAME(a_no_write_idle, state_ff == ST_IDLE, !ram_we,
      "amplitude RAM written while idle")
   `SGE_ASSERT_NEXT(a_accept_starts, req_fire, state_ff == ST_START,
      "accepted request did not start decode")
   `SGE_ASSERT_NEXT(a_rsp_from_result, !rsp_valid_ff && state_ff != ST_RESULT,
      !rsp_valid_ff, "result raised outside result state")
   `SGE_ASSERT_SAME(a_pair_in_range, state_ff == ST_RD_A, pair_ff <= last_pair,
      "pair counter beyond active vector")

endmodule

>>> design/sge_ram.sv
module sge_ram #(
   parameter int WIDTH = 36,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> sim/statevector_gate_engine_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the state-vector gate engine.
// Every accepted request beat is run through a behavioral model of the state vector
// kept inside this bench. Each measurement pushes its predicted expectation onto a queue,
// and each response beat is compared against the oldest entry on that queue.
module statevector_gate_engine_tb;
   import sge_pkg::*;

   localparam int    WATCHDOG_LIMIT = 20000;
   localparam int    SETTLE_CYCLES  = 3000;
   localparam longint Q_ONE         = 64'sd65536;

   logic clock;
   logic reset;

   sge_req_if req_ch ();
   sge_rsp_if rsp_ch ();
   sge_csr_if csr_ch ();

   statevector_gate_engine dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   // One expected measurement result.
   typedef struct {
      logic signed [AMP_W-1:0] value;
      logic [WIRE_W-1:0]       qb;
   } meas_result_type;

   // One row of the directed stimulus. When known is set the expectation is typed in
   // directly; otherwise the state-vector model supplies it.
   typedef struct {
      op_type                   op;
      int                       qa;
      int                       qc;
      int                       cosv;
      int                       sinv;
      bit                       known;
      int                       value;
   } stim_row_type;

   // Model of the amplitude memory and the qubit count register.
   longint       amp_re [DEPTH];
   longint       amp_im [DEPTH];
   int unsigned  qubit_reg;

   meas_result_type pending_meas[$];
   int           mismatch_count;
   int           idle_cycles;
   bit           no_gaps;
   int           rsp_stall;

   always #6 clock = ~clock;

   // Round a value with 32 fraction bits to 16 (half up), then clamp to +/-1.0.
   function automatic longint requantize(longint x);
      longint r;
      r = (x + 64'sd32768) >>> AMP_FRAC_BITS;
      if (r > Q_ONE) r = Q_ONE;
      if (r < -Q_ONE) r = -Q_ONE;
      return r;
   endfunction

   function automatic longint sext18(logic [17:0] v);
      return longint'(signed'(v));
   endfunction

   function automatic void load_ground_state();
      foreach (amp_re[i]) begin
         amp_re[i] = 0;
         amp_im[i] = 0;
      end
      amp_re[0] = Q_ONE;
   endfunction

   function automatic int unsigned active_count();
      if (qubit_reg < 1) return 1;
      if (qubit_reg > MAX_QUBITS) return MAX_QUBITS;
      return qubit_reg;
   endfunction

   // Apply one operation to the model. Returns 1 and fills res for a measurement.
   function automatic bit apply_operation(op_type op, int unsigned qa, int unsigned qc,
                                          logic [17:0] cos_bits, logic [17:0] sin_bits,
                                          output meas_result_type res);
      int unsigned n, dim, bitm, cbit, j;
      longint c, s, ar, ai, br, bi, p, acc, tr, ti;
      n    = active_count();
      dim  = 1 << n;
      c    = sext18(cos_bits);
      s    = sext18(sin_bits);
      bitm = 1 << qa;
      res.qb = qa[WIRE_W-1:0];
      res.value = '0;
      case (op)
         OP_RESET: begin
            load_ground_state();
            return 0;
         end
         OP_RX, OP_RY, OP_RZ: begin
            if (qa >= n) return 0;
            for (int unsigned i = 0; i < dim; i++) begin
               if (op == OP_RZ) begin
                  ar = amp_re[i];
                  ai = amp_im[i];
                  if (i & bitm) begin
                     amp_re[i] = requantize(ar * c - ai * s);
                     amp_im[i] = requantize(ar * s + ai * c);
                  end else begin
                     amp_re[i] = requantize(ar * c + ai * s);
                     amp_im[i] = requantize(ai * c - ar * s);
                  end
               end else if ((i & bitm) == 0) begin
                  j  = i | bitm;
                  ar = amp_re[i];
                  ai = amp_im[i];
                  br = amp_re[j];
                  bi = amp_im[j];
                  if (op == OP_RX) begin
                     amp_re[i] = requantize(ar * c + bi * s);
                     amp_im[i] = requantize(ai * c - br * s);
                     amp_re[j] = requantize(br * c + ai * s);
                     amp_im[j] = requantize(bi * c - ar * s);
                  end else begin
                     amp_re[i] = requantize(ar * c - br * s);
                     amp_im[i] = requantize(ai * c - bi * s);
                     amp_re[j] = requantize(ar * s + br * c);
                     amp_im[j] = requantize(ai * s + bi * c);
                  end
               end
            end
            return 0;
         end
         OP_CNOT: begin
            if (qa >= n || qc >= n || qa == qc) return 0;
            cbit = 1 << qc;
            for (int unsigned i = 0; i < dim; i++) begin
               if ((i & bitm) && (i & cbit) == 0) begin
                  j  = i | cbit;
                  tr = amp_re[i];
                  ti = amp_im[i];
                  amp_re[i] = amp_re[j];
                  amp_im[i] = amp_im[j];
                  amp_re[j] = tr;
                  amp_im[j] = ti;
               end
            end
            return 0;
         end
         default: begin
            if (qa >= n) return 1;
            acc = 0;
            for (int unsigned i = 0; i < dim; i++) begin
               ar = amp_re[i];
               ai = amp_im[i];
               if (op == OP_MEAS_Z) begin
                  p = ar * ar + ai * ai;
                  acc += (i & bitm) ? -p : p;
               end else if ((i & bitm) == 0) begin
                  j  = i | bitm;
                  br = amp_re[j];
                  bi = amp_im[j];
                  if (op == OP_MEAS_X) acc += ar * br + ai * bi;
                  else acc += ar * bi - ai * br;
               end
            end
            if (op != OP_MEAS_Z) acc *= 2;
            res.value = AMP_W'(requantize(acc));
            return 1;
         end
      endcase
   endfunction

   task automatic report_mismatch(string msg);
      mismatch_count++;
      $display("ERROR at %0t: %s", $realtime, msg);
   endtask

   // Send one request beat; the prediction is made once the beat is accepted.
   task automatic issue_op(op_type op, int unsigned qa, int unsigned qc,
                           logic [17:0] cosv, logic [17:0] sinv,
                           bit known = 0, int value = 0);
      int gap;
      meas_result_type res;
      gap = no_gaps ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.opcode      <= op;
      req_ch.wire_req    <= qa[WIRE_W-1:0];
      req_ch.second_wire <= qc[WIRE_W-1:0];
      req_ch.cosine      <= cosv;
      req_ch.sine        <= sinv;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      if (apply_operation(op, qa, qc, cosv, sinv, res)) begin
         if (known) res.value = AMP_W'(value);
         pending_meas.insert(pending_meas.size(), res);
      end
      @(negedge clock);
   endtask

   // Write the qubit count once the engine has drained its work.
   task automatic set_qubit_count(int unsigned count);
      req_ch.valid <= 1'b0;
      while (pending_meas.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_ch.valid         <= 1'b1;
      csr_ch.qubits_in_use <= count[QREG_W-1:0];
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      qubit_reg = count;
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // Angle-based cosine and sine most of the time, raw 18-bit patterns now and then.
   task automatic draw_trig(output logic [17:0] cosv, output logic [17:0] sinv);
      real a;
      if ($urandom_range(0, 9) == 0) begin
         cosv = 18'($urandom);
         sinv = 18'($urandom);
      end else begin
         a    = $urandom_range(0, 62831) / 10000.0;
         cosv = 18'($rtoi($cos(a) * 65536.0));
         sinv = 18'($rtoi($sin(a) * 65536.0));
      end
   endtask

   function automatic int unsigned draw_qubit();
      int unsigned n;
      n = active_count();
      if ($urandom_range(0, 99) < 88) return $urandom_range(0, n - 1);
      return $urandom_range(0, 15);
   endfunction

   // Response side: random stall before each beat, and a check at every accepted beat.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_ch.ready <= 1'b0;
         rsp_stall    <= rsp_stall - 1;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      meas_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         rsp_stall <= no_gaps ? 0 : $urandom_range(0, 18);
         if (pending_meas.size() == 0) begin
            report_mismatch($sformatf("unexpected result beat, wire %0d value %0d",
                                      rsp_ch.measured_wire, rsp_ch.expectation));
         end else begin
            want = pending_meas.pop_front();
            if (rsp_ch.expectation !== want.value)
               report_mismatch($sformatf("expectation got %0d want %0d (wire %0d)",
                                         rsp_ch.expectation, want.value, want.qb));
            if (rsp_ch.measured_wire !== want.qb)
               report_mismatch($sformatf("measured_wire got %0d want %0d",
                                         rsp_ch.measured_wire, want.qb));
         end
      end
   end

   // Watchdog: any beat on any channel counts as progress.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   initial begin
      stim_row_type  directed[$];
      logic [17:0]   cosv, sinv;
      int unsigned   op_pick, qa, qc;
      op_type        op;
      int            phase_counts[9] = '{120, 60, 100, 12, 60, 100, 80, 8, 40};
      int unsigned   phase_qubits[9] = '{2, 0, 5, 15, 1, 4, 6, 10, 3};

      clock                = 1'b0;
      reset                = 1'b1;
      no_gaps              = 1'b0;
      rsp_stall            = 0;
      mismatch_count       = 0;
      idle_cycles          = 0;
      req_ch.valid         = 1'b0;
      req_ch.opcode        = OP_RESET;
      req_ch.wire_req      = '0;
      req_ch.second_wire   = '0;
      req_ch.cosine        = '0;
      req_ch.sine          = '0;
      rsp_ch.ready         = 1'b0;
      csr_ch.valid         = 1'b0;
      csr_ch.qubits_in_use = '0;
      qubit_reg            = MAX_QUBITS;
      load_ground_state();

      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // Directed part at the reset qubit count of ten. Measurements of the ground
      // state and of inactive wires are known without the model.
      directed = '{
         '{OP_MEAS_Z, 0, 0, 0, 0, 1, 65536},
         '{OP_MEAS_X, 0, 0, 0, 0, 1, 0},
         '{OP_MEAS_Y, 3, 0, 0, 0, 1, 0},
         '{OP_MEAS_Z, 12, 0, 0, 0, 1, 0},
         '{OP_RY, 0, 0, 46341, 46341, 0, 0},
         '{OP_MEAS_X, 0, 0, 0, 0, 0, 0},
         '{OP_CNOT, 0, 1, 0, 0, 0, 0},
         '{OP_CNOT, 2, 2, 0, 0, 0, 0},
         '{OP_CNOT, 11, 0, 0, 0, 0, 0},
         '{OP_RX, 1, 0, -131072, 131071, 0, 0},
         '{OP_MEAS_Z, 1, 0, 0, 0, 0, 0},
         '{OP_RZ, 9, 0, 0, 65536, 0, 0},
         '{OP_MEAS_Y, 0, 0, 0, 0, 0, 0},
         '{OP_RX, 14, 0, 65536, 0, 0, 0},
         '{OP_RY, 9, 0, -65536, 65536, 0, 0},
         '{OP_MEAS_Z, 9, 0, 0, 0, 0, 0},
         '{OP_MEAS_X, 15, 0, 0, 0, 1, 0},
         '{OP_RESET, 0, 0, 0, 0, 0, 0},
         '{OP_MEAS_Z, 0, 0, 0, 0, 1, 65536},
         '{OP_MEAS_Z, 5, 0, 0, 0, 0, 0}
      };
      @(negedge clock);
      foreach (directed[k])
         issue_op(directed[k].op, directed[k].qa, directed[k].qc,
                  18'(directed[k].cosv), 18'(directed[k].sinv),
                  directed[k].known, directed[k].value);

      // Random phases. Each phase starts with a register write on a drained engine;
      // the qubit count reaches both extremes and the out-of-range codes.
      foreach (phase_counts[ph]) begin
         set_qubit_count(phase_qubits[ph]);
         no_gaps = (ph % 3 == 2);
         for (int k = 0; k < phase_counts[ph]; k++) begin
            op_pick = $urandom_range(0, 99);
            if (op_pick < 3) op = OP_RESET;
            else if (op_pick < 15) op = OP_RX;
            else if (op_pick < 30) op = OP_RY;
            else if (op_pick < 42) op = OP_RZ;
            else if (op_pick < 58) op = OP_CNOT;
            else if (op_pick < 72) op = OP_MEAS_Z;
            else if (op_pick < 86) op = OP_MEAS_X;
            else op = OP_MEAS_Y;
            qa = draw_qubit();
            qc = draw_qubit();
            draw_trig(cosv, sinv);
            issue_op(op, qa, qc, cosv, sinv);
         end
      end

      req_ch.valid <= 1'b0;
      while (pending_meas.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
